// File: hw/rtl/postfix_expression_evaluator_defines.svh
// assertion macros used by the checker file
`ifndef POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PEE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define PEE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/pee_pkg.sv
package pee_pkg;

    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 7;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_op OP_PUSH = 3'd0;
    localparam t_op OP_ADD  = 3'd1;
    localparam t_op OP_SUB  = 3'd2;
    localparam t_op OP_MUL  = 3'd3;
    localparam t_op OP_DIV  = 3'd4;

    localparam t_status ST_OK       = 3'd0;
    localparam t_status ST_MISSING  = 3'd1;
    localparam t_status ST_DIVZERO  = 3'd2;
    localparam t_status ST_OVERFLOW = 3'd3;
    localparam t_status ST_EMPTY    = 3'd4;

    typedef struct packed {
        logic load;
        logic push;
        logic overflow;
        logic missing_empty;
        logic missing_one;
        logic alu_commit;
        logic div_start;
        logic div_commit;
        logic div_zero;
        logic report;
    } t_cmd;

    typedef struct packed {
        logic is_push;
        logic is_arith;
        logic is_div;
        logic err_set;
        logic depth_zero;
        logic depth_one;
        logic full;
        logic den_zero;
        logic div_done;
        logic last;
        logic out_busy;
    } t_sts;

endpackage

// File: hw/rtl/pee_tok_if.sv
interface pee_tok_if;
    logic                         valid;
    logic                         ready;
    logic [pee_pkg::OP_W-1:0]     op;
    logic signed [pee_pkg::DATA_W-1:0] number;
    logic                         last;

    modport source (output valid, output op, output number, output last, input ready);
    modport sink   (input valid, input op, input number, input last, output ready);
endinterface

// File: hw/rtl/pee_res_if.sv
interface pee_res_if;
    logic                                valid;
    logic                                ready;
    logic signed [pee_pkg::DATA_W-1:0]   top_value;
    logic [pee_pkg::STATUS_W-1:0]        status;
    logic [pee_pkg::DEPTH_OUT_W-1:0]     stack_depth;

    modport source (output valid, output top_value, output status, output stack_depth,
                    input ready);
    modport sink   (input valid, input top_value, input status, input stack_depth,
                    output ready);
endinterface

// File: hw/rtl/pee_ram.sv
module pee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pee_div.sv
module pee_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pee_pkg::DATA_W-1:0] i_num,
    input  logic [pee_pkg::DATA_W-1:0] i_den,
    output logic                       o_done,
    output logic [pee_pkg::DATA_W-1:0] o_quo
);

    localparam int W     = pee_pkg::DATA_W;
    localparam int CNT_W = $clog2(W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_quo;
    logic [W-1:0]     r_den;
    logic             r_neg;

    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W:0]   shifted;
    logic [W:0]   diff;

    assign num_mag = i_num[W-1] ? (W'(0) - i_num) : i_num;
    assign den_mag = i_den[W-1] ? (W'(0) - i_den) : i_den;
    assign shifted = {r_rem, r_quo[W-1]};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= num_mag;
            r_den <= den_mag;
            r_neg <= i_num[W-1] ^ i_den[W-1];
        end else if (r_busy && (r_cnt != '0)) begin
            r_rem <= diff[W] ? shifted[W-1:0] : diff[W-1:0];
            r_quo <= {r_quo[W-2:0], ~diff[W]};
        end
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo  = r_neg ? (W'(0) - r_quo) : r_quo;

endmodule

// File: hw/rtl/pee_dp.sv
module pee_dp #(
    parameter int STACK_DEPTH = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [pee_pkg::OP_W-1:0]        i_op,
    input  logic [pee_pkg::DATA_W-1:0]      i_number,
    input  logic                            i_last,
    input  pee_pkg::t_cmd                   i_cmd,
    output pee_pkg::t_sts                   o_sts,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pee_pkg::DATA_W-1:0]      o_top_value,
    output logic [pee_pkg::STATUS_W-1:0]    o_status,
    output logic [pee_pkg::DEPTH_OUT_W-1:0] o_stack_depth
);

    localparam int W       = pee_pkg::DATA_W;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = $clog2(STACK_DEPTH);

    pee_pkg::t_op     r_op;
    logic [W-1:0]     r_num;
    logic             r_last;
    logic [DEPTH_W-1:0] r_depth;
    pee_pkg::t_status r_err;
    logic [W-1:0]     r_tos;

    logic                            r_out_valid;
    logic [W-1:0]                    r_out_top;
    pee_pkg::t_status                r_out_status;
    logic [pee_pkg::DEPTH_OUT_W-1:0] r_out_depth;

    logic [W-1:0]      left;
    logic [W-1:0]      alu_res;
    logic [W-1:0]      quo;
    logic              div_done;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    pee_pkg::t_status  end_status;

    // top of stack lives in r_tos, the entries below it in the ram
    assign ram_we    = i_cmd.push && (r_depth != '0);
    assign ram_waddr = ADDR_W'(r_depth - DEPTH_W'(1));
    assign ram_raddr = ADDR_W'(r_depth - DEPTH_W'(2));

    pee_ram #(
        .WIDTH (W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_tos),
        .i_raddr (ram_raddr),
        .o_rdata (left)
    );

    pee_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (left),
        .i_den   (r_tos),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    always_comb begin
        case (r_op)
            pee_pkg::OP_ADD: alu_res = left + r_tos;
            pee_pkg::OP_SUB: alu_res = left - r_tos;
            pee_pkg::OP_MUL: alu_res = W'(left * r_tos);
            default:         alu_res = left;
        endcase
    end

    always_comb begin
        if (r_err != pee_pkg::ST_OK) begin
            end_status = r_err;
        end else if (r_depth == '0) begin
            end_status = pee_pkg::ST_EMPTY;
        end else begin
            end_status = pee_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_num  <= i_number;
            r_last <= i_last;
        end
        if (i_cmd.push) begin
            r_tos <= r_num;
        end else if (i_cmd.alu_commit) begin
            r_tos <= alu_res;
        end else if (i_cmd.div_commit) begin
            r_tos <= quo;
        end
        if (i_cmd.report) begin
            r_out_top    <= (r_depth != '0) ? r_tos : '0;
            r_out_status <= end_status;
            r_out_depth  <= pee_pkg::DEPTH_OUT_W'(r_depth);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth     <= '0;
            r_err       <= pee_pkg::ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push) begin
                r_depth <= r_depth + DEPTH_W'(1);
            end else if (i_cmd.alu_commit || i_cmd.div_commit) begin
                r_depth <= r_depth - DEPTH_W'(1);
            end else if (i_cmd.missing_one || i_cmd.report) begin
                r_depth <= '0;
            end
            if (i_cmd.overflow) begin
                r_err <= pee_pkg::ST_OVERFLOW;
            end else if (i_cmd.missing_empty || i_cmd.missing_one) begin
                r_err <= pee_pkg::ST_MISSING;
            end else if (i_cmd.div_zero) begin
                r_err <= pee_pkg::ST_DIVZERO;
            end else if (i_cmd.report) begin
                r_err <= pee_pkg::ST_OK;
            end
            if (i_cmd.report) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_sts.is_push    = (r_op == pee_pkg::OP_PUSH);
        o_sts.is_arith   = (r_op == pee_pkg::OP_ADD) || (r_op == pee_pkg::OP_SUB)
                        || (r_op == pee_pkg::OP_MUL) || (r_op == pee_pkg::OP_DIV);
        o_sts.is_div     = (r_op == pee_pkg::OP_DIV);
        o_sts.err_set    = (r_err != pee_pkg::ST_OK);
        o_sts.depth_zero = (r_depth == '0);
        o_sts.depth_one  = (r_depth == DEPTH_W'(1));
        o_sts.full       = (r_depth == DEPTH_W'(STACK_DEPTH));
        o_sts.den_zero   = (r_tos == '0);
        o_sts.div_done   = div_done;
        o_sts.last       = r_last;
        o_sts.out_busy   = r_out_valid && !i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_status      = r_out_status;
    assign o_stack_depth = r_out_depth;

endmodule

// File: hw/rtl/pee_ctrl.sv
module pee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  pee_pkg::t_sts i_sts,
    output pee_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_DIV    = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_FINISH;
                if (i_sts.err_set) begin
                    n_state = S_FINISH;
                end else if (i_sts.is_push) begin
                    if (i_sts.full) begin
                        o_cmd.overflow = 1'b1;
                    end else begin
                        o_cmd.push = 1'b1;
                    end
                end else if (i_sts.is_arith) begin
                    if (i_sts.depth_zero) begin
                        o_cmd.missing_empty = 1'b1;
                    end else if (i_sts.depth_one) begin
                        o_cmd.missing_one = 1'b1;
                    end else if (i_sts.is_div) begin
                        if (i_sts.den_zero) begin
                            o_cmd.div_zero = 1'b1;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end else begin
                        o_cmd.alu_commit = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.div_commit = 1'b1;
                    n_state          = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!i_sts.last) begin
                    n_state = S_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// File: hw/rtl/postfix_expression_evaluator.sv
// Postfix integer expression evaluator. Tokens arrive one beat at a time on i_tok; a push
// token stacks its number, an operator pops right then left and stacks the 32-bit wrapping
// result (division truncates toward zero). The beat marked last produces one result beat
// on o_res with the top of stack, the status and the depth, and clears the stack. The first
// error of an expression (missing operand, divide by zero, overflow) is kept and later
// tokens are ignored until the last one. Push, add, subtract, multiply and ignored tokens
// pass the decode and finish states before i_tok.ready returns; divide also waits in the div
// state on the radix-2 divider that forms one quotient bit per cycle. A last token waits in
// its finish state while an earlier result beat is still held on o_res. The stack sits in
// one ram with a registered read, with the top entry kept in a register; no clearing pass is needed.
module postfix_expression_evaluator #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pee_tok_if.sink    i_tok,
    pee_res_if.source  o_res
);

    pee_pkg::t_cmd cmd;
    pee_pkg::t_sts sts;

    pee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tok.valid),
        .o_in_ready (i_tok.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pee_dp #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op          (i_tok.op),
        .i_number      (i_tok.number),
        .i_last        (i_tok.last),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_out_ready   (o_res.ready),
        .o_out_valid   (o_res.valid),
        .o_top_value   (o_res.top_value),
        .o_status      (o_res.status),
        .o_stack_depth (o_res.stack_depth)
    );

endmodule

// File: hw/rtl/pee_checker.sv
`include "postfix_expression_evaluator_defines.svh"

module pee_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [pee_pkg::DATA_W-1:0]      i_top_value,
    input logic [pee_pkg::STATUS_W-1:0]    i_status,
    input logic [pee_pkg::DEPTH_OUT_W-1:0] i_stack_depth
);

    `PEE_ASSERT_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_top_value) && $stable(i_status) && $stable(i_stack_depth), "result beat changed while stalled")

    `PEE_ASSERT_IMP(a_empty_report, i_out_valid && (i_status == pee_pkg::ST_EMPTY), (i_stack_depth == '0) && (i_top_value == '0), "empty status with values left")

    `PEE_ASSERT_NXT(a_one_token, i_in_valid && i_in_ready, !i_in_ready, "token taken while one is at work")

    `PEE_ASSERT_NXT(a_result_after_token, !i_out_valid && !(i_in_valid && i_in_ready) && !i_in_ready && $past(i_in_ready), !i_out_valid, "result beat without a token at work")

endmodule

bind postfix_expression_evaluator pee_checker u_pee_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_tok.valid),
    .i_in_ready    (i_tok.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_top_value   (o_res.top_value),
    .i_status      (o_res.status),
    .i_stack_depth (o_res.stack_depth)
);
